/* design/rusi_pkg.sv */
// ----------------------------------------------------------------------------
// rusi_pkg
// Shared types and constants for the ray / unit cube slab intersect block.
// ----------------------------------------------------------------------------
package rusi_pkg;

    localparam int unsigned EPS_WIDTH = 16;
    localparam int unsigned AXES      = 3;

    typedef logic [EPS_WIDTH-1:0] t_eps;

    localparam t_eps EPS_RESET = t_eps'(7);

endpackage

/* design/rusi_lane.sv */
// ----------------------------------------------------------------------------
// rusi_lane
// One axis: slab bounds through two pipelined restoring dividers, one
// quotient bit per stage, then saturation and ordering.
// ----------------------------------------------------------------------------
module rusi_lane #(
    parameter int unsigned FRAC_BITS   = 16,
    parameter int unsigned COORD_WIDTH = 32,
    localparam int unsigned NQ         = COORD_WIDTH + 1 + FRAC_BITS
) (
    input  logic                          i_clk,
    input  logic [NQ+1:0]                 i_en,
    input  logic signed [COORD_WIDTH-1:0] i_origin,
    input  logic signed [COORD_WIDTH-1:0] i_dir,
    input  rusi_pkg::t_eps                i_eps,
    output logic signed [COORD_WIDTH-1:0] o_lo,
    output logic signed [COORD_WIDTH-1:0] o_hi
);
    import rusi_pkg::*;

    localparam int unsigned W  = COORD_WIDTH;
    localparam int unsigned NW = W + 1;

    localparam logic signed [NW-1:0] ONE_FX = NW'(1) << FRAC_BITS;
    localparam logic [W-1:0]  POS_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0]  NEG_MIN = {1'b1, {(W-1){1'b0}}};
    localparam logic [NQ-1:0] CAP     = NQ'(1) << (W - 1);

    logic signed [NW-1:0] oe;
    logic signed [NW-1:0] num_lo;
    logic signed [NW-1:0] num_hi;
    logic [NW-1:0]        mag_lo;
    logic [NW-1:0]        mag_hi;
    logic [W-1:0]         mag_d;

    always_comb begin
        oe     = {i_origin[W-1], i_origin};
        num_lo = -ONE_FX - oe;
        num_hi = ONE_FX - oe;
        mag_lo = num_lo[NW-1] ? NW'(-num_lo) : NW'(num_lo);
        mag_hi = num_hi[NW-1] ? NW'(-num_hi) : NW'(num_hi);
        mag_d  = i_dir[W-1] ? W'(-i_dir) : W'(i_dir);
    end

    logic [W-1:0]  r_rem_lo [0:NQ];
    logic [W-1:0]  r_rem_hi [0:NQ];
    logic [NQ-1:0] r_num_lo [0:NQ];
    logic [NQ-1:0] r_num_hi [0:NQ];
    logic [NQ-1:0] r_q_lo   [0:NQ];
    logic [NQ-1:0] r_q_hi   [0:NQ];
    logic [W-1:0]  r_m      [0:NQ];
    logic          r_neg_lo [0:NQ];
    logic          r_neg_hi [0:NQ];
    logic          r_par    [0:NQ];
    logic          r_in     [0:NQ];

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_rem_lo[0] <= '0;
            r_rem_hi[0] <= '0;
            r_q_lo[0]   <= '0;
            r_q_hi[0]   <= '0;
            r_num_lo[0] <= {mag_lo, {FRAC_BITS{1'b0}}};
            r_num_hi[0] <= {mag_hi, {FRAC_BITS{1'b0}}};
            r_m[0]      <= mag_d;
            r_neg_lo[0] <= num_lo[NW-1] ^ i_dir[W-1];
            r_neg_hi[0] <= num_hi[NW-1] ^ i_dir[W-1];
            r_par[0]    <= (mag_d <= W'(i_eps));
            r_in[0]     <= (oe >= -ONE_FX) && (oe <= ONE_FX);
        end
    end

    genvar k;
    generate
        for (k = 1; k <= NQ; k++) begin : g_step
            logic [W:0]   t_lo;
            logic [W:0]   t_hi;
            logic         ge_lo;
            logic         ge_hi;
            logic [W-1:0] n_rem_lo;
            logic [W-1:0] n_rem_hi;

            always_comb begin
                t_lo     = {r_rem_lo[k-1], r_num_lo[k-1][NQ-1]};
                t_hi     = {r_rem_hi[k-1], r_num_hi[k-1][NQ-1]};
                ge_lo    = t_lo >= {1'b0, r_m[k-1]};
                ge_hi    = t_hi >= {1'b0, r_m[k-1]};
                n_rem_lo = ge_lo ? W'(t_lo - {1'b0, r_m[k-1]}) : W'(t_lo);
                n_rem_hi = ge_hi ? W'(t_hi - {1'b0, r_m[k-1]}) : W'(t_hi);
            end

            always_ff @(posedge i_clk) begin
                if (i_en[k]) begin
                    r_rem_lo[k] <= n_rem_lo;
                    r_rem_hi[k] <= n_rem_hi;
                    r_q_lo[k]   <= {r_q_lo[k-1][NQ-2:0], ge_lo};
                    r_q_hi[k]   <= {r_q_hi[k-1][NQ-2:0], ge_hi};
                    r_num_lo[k] <= r_num_lo[k-1] << 1;
                    r_num_hi[k] <= r_num_hi[k-1] << 1;
                    r_m[k]      <= r_m[k-1];
                    r_neg_lo[k] <= r_neg_lo[k-1];
                    r_neg_hi[k] <= r_neg_hi[k-1];
                    r_par[k]    <= r_par[k-1];
                    r_in[k]     <= r_in[k-1];
                end
            end
        end
    endgenerate

    logic signed [W-1:0] a;
    logic signed [W-1:0] b;
    logic signed [W-1:0] n_lo;
    logic signed [W-1:0] n_hi;

    always_comb begin
        if (r_neg_lo[NQ]) begin
            a = (r_q_lo[NQ] >= CAP) ? NEG_MIN : W'(-r_q_lo[NQ]);
        end else begin
            a = (r_q_lo[NQ] >= CAP) ? POS_MAX : r_q_lo[NQ][W-1:0];
        end
        if (r_neg_hi[NQ]) begin
            b = (r_q_hi[NQ] >= CAP) ? NEG_MIN : W'(-r_q_hi[NQ]);
        end else begin
            b = (r_q_hi[NQ] >= CAP) ? POS_MAX : r_q_hi[NQ][W-1:0];
        end
        if (r_par[NQ]) begin
            n_lo = r_in[NQ] ? NEG_MIN : POS_MAX;
            n_hi = r_in[NQ] ? POS_MAX : NEG_MIN;
        end else if (a > b) begin
            n_lo = b;
            n_hi = a;
        end else begin
            n_lo = a;
            n_hi = b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[NQ+1]) begin
            o_lo <= n_lo;
            o_hi <= n_hi;
        end
    end

endmodule

/* design/rusi_merge.sv */
// ----------------------------------------------------------------------------
// rusi_merge
// Combine the three axis slabs: largest near, smallest far, hit flag.
// ----------------------------------------------------------------------------
module rusi_merge #(
    parameter int unsigned COORD_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic signed [COORD_WIDTH-1:0] i_lo_x,
    input  logic signed [COORD_WIDTH-1:0] i_lo_y,
    input  logic signed [COORD_WIDTH-1:0] i_lo_z,
    input  logic signed [COORD_WIDTH-1:0] i_hi_x,
    input  logic signed [COORD_WIDTH-1:0] i_hi_y,
    input  logic signed [COORD_WIDTH-1:0] i_hi_z,
    output logic                          o_hit,
    output logic signed [COORD_WIDTH-1:0] o_t_near,
    output logic signed [COORD_WIDTH-1:0] o_t_far
);
    import rusi_pkg::*;

    logic signed [COORD_WIDTH-1:0] near_xy;
    logic signed [COORD_WIDTH-1:0] far_xy;
    logic signed [COORD_WIDTH-1:0] n_near;
    logic signed [COORD_WIDTH-1:0] n_far;

    always_comb begin
        near_xy = (i_lo_x > i_lo_y) ? i_lo_x : i_lo_y;
        far_xy  = (i_hi_x < i_hi_y) ? i_hi_x : i_hi_y;
        n_near  = (i_lo_z > near_xy) ? i_lo_z : near_xy;
        n_far   = (i_hi_z < far_xy) ? i_hi_z : far_xy;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_t_near <= n_near;
            o_t_far  <= n_far;
            o_hit    <= (n_near <= n_far);
        end
    end

endmodule

/* design/ray_unit_cube_slab_intersect.sv */
// ----------------------------------------------------------------------------
// ray_unit_cube_slab_intersect
// Ray against the [-1,1] cube by the slab method, three axis lanes in parallel.
// ----------------------------------------------------------------------------
// Pipeline: one stage per quotient bit of the restoring dividers in each lane.
// Throughput: one request per cycle unless o_stall is high; empty stages
//   collapse under output stall.
// Reset: synchronous active low, clears all valid bits and sets epsilon to 7.
// ----------------------------------------------------------------------------
module ray_unit_cube_slab_intersect #(
    parameter int unsigned FRAC_BITS   = 16,
    parameter int unsigned COORD_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  rusi_pkg::t_eps                i_cfg_wdata,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [COORD_WIDTH-1:0] i_origin_x,
    input  logic signed [COORD_WIDTH-1:0] i_origin_y,
    input  logic signed [COORD_WIDTH-1:0] i_origin_z,
    input  logic signed [COORD_WIDTH-1:0] i_dir_x,
    input  logic signed [COORD_WIDTH-1:0] i_dir_y,
    input  logic signed [COORD_WIDTH-1:0] i_dir_z,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_hit,
    output logic signed [COORD_WIDTH-1:0] o_t_near,
    output logic signed [COORD_WIDTH-1:0] o_t_far
);
    import rusi_pkg::*;

    localparam int unsigned NQ = COORD_WIDTH + 1 + FRAC_BITS;
    localparam int unsigned NS = NQ + 2;

    t_eps          r_eps;
    logic [NS-1:0] r_v;
    logic [NS-1:0] en;
    logic          en_out;
    logic          r_out_valid;

    assign en_out = !r_out_valid || !i_stall;
    assign en[NS-1] = !r_v[NS-1] || en_out;

    genvar k;
    generate
        for (k = 0; k < NS - 1; k++) begin : g_en
            assign en[k] = !r_v[k] || en[k+1];
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eps <= EPS_RESET;
        end else if (i_cfg_we) begin
            r_eps <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            for (int s = 0; s < NS; s++) begin
                if (en[s]) begin
                    r_v[s] <= (s == 0) ? i_valid : r_v[(s == 0) ? 0 : s - 1];
                end
            end
            if (en_out) begin
                r_out_valid <= r_v[NS-1];
            end
        end
    end

    assign o_stall = !en[0];
    assign o_valid = r_out_valid;

    logic signed [COORD_WIDTH-1:0] lo_x, lo_y, lo_z, hi_x, hi_y, hi_z;

    rusi_lane #(.FRAC_BITS(FRAC_BITS), .COORD_WIDTH(COORD_WIDTH)) u_lane_x (
        .i_clk(i_clk), .i_en(en), .i_origin(i_origin_x), .i_dir(i_dir_x),
        .i_eps(r_eps), .o_lo(lo_x), .o_hi(hi_x)
    );

    rusi_lane #(.FRAC_BITS(FRAC_BITS), .COORD_WIDTH(COORD_WIDTH)) u_lane_y (
        .i_clk(i_clk), .i_en(en), .i_origin(i_origin_y), .i_dir(i_dir_y),
        .i_eps(r_eps), .o_lo(lo_y), .o_hi(hi_y)
    );

    rusi_lane #(.FRAC_BITS(FRAC_BITS), .COORD_WIDTH(COORD_WIDTH)) u_lane_z (
        .i_clk(i_clk), .i_en(en), .i_origin(i_origin_z), .i_dir(i_dir_z),
        .i_eps(r_eps), .o_lo(lo_z), .o_hi(hi_z)
    );

    rusi_merge #(.COORD_WIDTH(COORD_WIDTH)) u_merge (
        .i_clk(i_clk), .i_en(en_out),
        .i_lo_x(lo_x), .i_lo_y(lo_y), .i_lo_z(lo_z),
        .i_hi_x(hi_x), .i_hi_y(hi_y), .i_hi_z(hi_z),
        .o_hit(o_hit), .o_t_near(o_t_near), .o_t_far(o_t_far)
    );

endmodule

/* design/rusi_checker.sv */
// ----------------------------------------------------------------------------
// rusi_checker
// Port-level checks for the slab intersect block.
// ----------------------------------------------------------------------------
module rusi_checker #(
    parameter int unsigned COORD_WIDTH = 32
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_valid,
    input logic                          i_stall,
    input logic                          o_hit,
    input logic signed [COORD_WIDTH-1:0] o_t_near,
    input logic signed [COORD_WIDTH-1:0] o_t_far
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_t_near) && $stable(o_t_far)
            && $stable(o_hit))
        else $error("stalled result changed");

    a_hit_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_hit |-> o_t_near <= o_t_far)
        else $error("hit with near above far");

    a_miss_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_hit |-> o_t_near > o_t_far)
        else $error("miss with near not above far");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("valid right after reset");

endmodule

bind ray_unit_cube_slab_intersect rusi_checker #(.COORD_WIDTH(COORD_WIDTH)) u_rusi_checker (.*);
